>>> rtl/led_pwm_greyscale_shift_controller_assert.svh
// assertion macros used by the top rtl file
`ifndef LED_PWM_GREYSCALE_SHIFT_CONTROLLER_ASSERT_SVH
`define LED_PWM_GREYSCALE_SHIFT_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LPGSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LPGSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPGSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LPGSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/lpgsc_pkg.sv
`timescale 1ns / 1ps
package lpgsc_pkg;

  localparam int CHANNELS    = 16;
  localparam int WORD_W      = 12;
  localparam int MODULES_DEF = 2;
  localparam int SLOT_MAX_W  = 6;
  localparam int PERIOD_W    = 16;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET      = 16'd200;
  localparam logic [CFG_AW-1:0]   ADDR_FRAME_PERIOD = 3'd0;

  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_GET  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_BLANK  = 2'd2,
    CMD_STREAM = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    hit;
    logic [SLOT_MAX_W-1:0]   slot;
    logic [WORD_W-1:0]       word;
  } cmd_t;

endpackage

>>> rtl/lpgsc_ram.sv
`timescale 1ns / 1ps
module lpgsc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lpgsc_front.sv
`timescale 1ns / 1ps
module lpgsc_front import lpgsc_pkg::*; #(
  parameter int MODULES = MODULES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_action,
  input  logic [1:0]        in_module_req,
  input  logic [3:0]        in_channel,
  input  logic [WORD_W-1:0] in_duty,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cmd_t              cmd,
  output logic              cmd_push,
  input  logic              q_full
);

  logic [PERIOD_W-1:0] frame_period_r, frame_period_nxt;
  logic [PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic                pending_r, pending_nxt;
  logic                accept;
  logic                mod_hit;
  logic [2:0]          mod_off;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   count_inc;
  logic                cfg_wr;

  assign full    = q_full;
  assign accept  = push & ~q_full;
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (paddr == ADDR_FRAME_PERIOD) ?
                   {{(CFG_DW-PERIOD_W){1'b0}}, frame_period_r} : '0;

  assign mod_hit = (in_module_req != 2'd0) && ({1'b0, in_module_req} <= 3'(MODULES));
  assign mod_off = 3'(MODULES) - {1'b0, in_module_req};

  // zero period behaves as one
  assign period    = (frame_period_r == '0) ? PERIOD_W'(1) : frame_period_r;
  assign count_inc = {1'b0, tick_count_r} + {{PERIOD_W{1'b0}}, 1'b1};

  always_comb begin
    frame_period_nxt = frame_period_r;
    if (cfg_wr && paddr == ADDR_FRAME_PERIOD) begin
      frame_period_nxt = pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.hit        = mod_hit;
    cmd.slot       = {mod_off[1:0], ~in_channel};
    cmd.word       = ~in_duty;
    cmd_push       = 1'b0;
    pending_nxt    = pending_r;
    tick_count_nxt = tick_count_r;
    if (accept) begin
      unique case (in_action)
        ACT_SET: begin
          if (mod_hit) begin
            cmd.kind    = CMD_SET;
            cmd_push    = 1'b1;
            pending_nxt = 1'b1;
          end
        end
        ACT_GET: begin
          cmd.kind = CMD_GET;
          cmd_push = 1'b1;
        end
        ACT_TICK: begin
          tick_count_nxt = (count_inc >= {1'b0, period}) ? '0 : count_inc[PERIOD_W-1:0];
          if (tick_count_r == '0) begin
            cmd_push = 1'b1;
            if (pending_r) begin
              cmd.kind    = CMD_STREAM;
              pending_nxt = 1'b0;
            end else begin
              cmd.kind = CMD_BLANK;
            end
          end
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= PERIOD_RESET;
      tick_count_r   <= '0;
      pending_r      <= 1'b1;
    end else begin
      frame_period_r <= frame_period_nxt;
      tick_count_r   <= tick_count_nxt;
      pending_r      <= pending_nxt;
    end
  end

endmodule

>>> rtl/lpgsc_cmd_q.sv
`timescale 1ns / 1ps
module lpgsc_cmd_q import lpgsc_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic q_full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign rd_cmd  = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/lpgsc_back.sv
`timescale 1ns / 1ps
module lpgsc_back import lpgsc_pkg::*; #(
  parameter int MODULES = MODULES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              q_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] out_read_duty,
  output logic              out_blank_pulse,
  output logic              out_shift_valid,
  output logic [WORD_W-1:0] out_shift_word,
  output logic              out_latch_pulse,
  output logic              out_last
);

  localparam int DEPTH  = MODULES * CHANNELS;
  localparam int SLOT_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              stream_r, stream_nxt;
  logic              hit_r, hit_nxt;
  logic              wvalid_r [DEPTH];
  logic              load_out;
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] stored;
  logic              idx_final;
  logic [SLOT_W-1:0] cmd_slot;

  logic [WORD_W-1:0] rd_duty_r, rd_duty_nxt;
  logic              blank_r, blank_nxt;
  logic              svalid_r, svalid_nxt;
  logic [WORD_W-1:0] sword_r, sword_nxt;
  logic              latch_r, latch_nxt;
  logic              last_r, last_nxt;

  lpgsc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(q_cmd.word),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign cmd_slot  = q_cmd.slot[SLOT_W-1:0];
  // entries never written read as zero
  assign stored    = wvalid_r[idx_r] ? ram_q : '0;
  assign idx_final = (idx_r == SLOT_W'(DEPTH - 1));
  assign empty     = (state_r != ST_OUT);

  assign out_read_duty   = rd_duty_r;
  assign out_blank_pulse = blank_r;
  assign out_shift_valid = svalid_r;
  assign out_shift_word  = sword_r;
  assign out_latch_pulse = latch_r;
  assign out_last        = last_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    stream_nxt  = stream_r;
    hit_nxt     = hit_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cmd_slot;
    ram_re      = 1'b0;
    ram_raddr   = cmd_slot;
    load_out    = 1'b0;
    rd_duty_nxt = '0;
    blank_nxt   = 1'b0;
    svalid_nxt  = 1'b0;
    sword_nxt   = '0;
    latch_nxt   = 1'b0;
    last_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_SET: begin
              ram_we = 1'b1;
            end
            CMD_GET: begin
              ram_re     = 1'b1;
              idx_nxt    = cmd_slot;
              hit_nxt    = q_cmd.hit;
              stream_nxt = 1'b0;
              state_nxt  = ST_RD;
            end
            CMD_BLANK: begin
              load_out  = 1'b1;
              blank_nxt = 1'b1;
              last_nxt  = 1'b1;
              state_nxt = ST_OUT;
            end
            CMD_STREAM: begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              idx_nxt    = '0;
              stream_nxt = 1'b1;
              state_nxt  = ST_RD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD: begin
        load_out  = 1'b1;
        state_nxt = ST_OUT;
        if (stream_r) begin
          blank_nxt  = (idx_r == '0);
          svalid_nxt = 1'b1;
          sword_nxt  = stored;
          latch_nxt  = idx_final;
          last_nxt   = idx_final;
        end else begin
          rd_duty_nxt = hit_r ? ~stored : '0;
          last_nxt    = 1'b1;
        end
      end
      ST_OUT: begin
        if (pop) begin
          if (stream_r && !idx_final) begin
            idx_nxt   = idx_r + SLOT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_r + SLOT_W'(1);
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rd_duty_r <= rd_duty_nxt;
      blank_r   <= blank_nxt;
      svalid_r  <= svalid_nxt;
      sword_r   <= sword_nxt;
      latch_r   <= latch_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      stream_r <= 1'b0;
      hit_r    <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        wvalid_r[i] <= 1'b0;
      end
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      stream_r <= stream_nxt;
      hit_r    <= hit_nxt;
      if (ram_we) begin
        wvalid_r[ram_waddr] <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/led_pwm_greyscale_shift_controller.sv
// channel   direction  handshake                      payload
// input     in         push / full                    in_action in_module_req in_channel in_duty
// result    out        empty / pop                    out_read_duty out_blank_pulse ...
// config    in/out     psel penable pwrite / pready   paddr pwdata prdata (frame_period at 0)
//
// an item is classified combinationally in the front and queued for the back (two entries)
// set: the back writes the store at the pop; get: the pop reads the store, ST_RD registers
// the result; frame-start tick: a registered blank result, or a stream of words, one per pop;
// results are held in an output register until popped; the back waits, the front keeps taking
// items until the command queue fills; synchronous active-low reset clears the control state
`timescale 1ns / 1ps
`include "led_pwm_greyscale_shift_controller_assert.svh"
module led_pwm_greyscale_shift_controller import lpgsc_pkg::*; #(
  parameter int MODULES = MODULES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_action,
  input  logic [1:0]        in_module_req,
  input  logic [3:0]        in_channel,
  input  logic [WORD_W-1:0] in_duty,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] out_read_duty,
  output logic              out_blank_pulse,
  output logic              out_shift_valid,
  output logic [WORD_W-1:0] out_shift_word,
  output logic              out_latch_pulse,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cmd_t front_cmd, back_cmd;
  logic front_push;
  logic q_full, q_empty, q_pop;

  lpgsc_front #(
    .MODULES(MODULES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_action    (in_action),
    .in_module_req(in_module_req),
    .in_channel   (in_channel),
    .in_duty      (in_duty),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cmd          (front_cmd),
    .cmd_push     (front_push),
    .q_full       (q_full)
  );

  lpgsc_cmd_q #(
    .DEPTH(CMDQ_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (front_push),
    .wr_cmd (front_cmd),
    .q_full (q_full),
    .rd     (q_pop),
    .rd_cmd (back_cmd),
    .q_empty(q_empty)
  );

  lpgsc_back #(
    .MODULES(MODULES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_cmd          (back_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_read_duty  (out_read_duty),
    .out_blank_pulse(out_blank_pulse),
    .out_shift_valid(out_shift_valid),
    .out_shift_word (out_shift_word),
    .out_latch_pulse(out_latch_pulse),
    .out_last       (out_last)
  );

  // the back only takes a command while it has no result waiting
  `LPGSC_ASSERT_IMP(a_pop_when_idle, clk, rst_n, q_pop, !q_empty && empty, "bad queue pop")
  // latch only on the final shifted word
  `LPGSC_ASSERT_IMP(a_latch_last, clk, rst_n, !empty && out_latch_pulse,
    out_last && out_shift_valid, "latch without last word")
  // each streamed word after the first is read from the store before it is shown
  `LPGSC_ASSERT_NXT(a_stream_gap, clk, rst_n, !empty && pop && out_shift_valid && !out_last,
    empty, "stream word shown without read")

endmodule
